### hw/rtl/hlq_pkg.sv
package hlq_pkg;

    // field widths of the stream items
    localparam int HUB_VERTEX_W = 20;
    localparam int HUB_DIST_W   = 31;
    localparam int SUM_W        = 32;

    // slave tdata: hub_vertex, hub_distance, zero padding to whole bytes
    localparam int S_VTX_LSB   = 0;
    localparam int S_DIST_LSB  = HUB_VERTEX_W;
    localparam int S_TDATA_W   = ((HUB_VERTEX_W + HUB_DIST_W + 7) / 8) * 8;
    // slave tuser: list_select, entry_valid
    localparam int S_TUSER_W   = 2;
    localparam int S_SEL_BIT   = 0;
    localparam int S_VALID_BIT = 1;

    // master tdata: best_distance; master tuser: found_common, list_overflow
    localparam int M_TDATA_W   = SUM_W;
    localparam int M_TUSER_W   = 2;

    localparam int MAX_LABELS_DEF  = 1024;
    localparam int VERTEX_BITS_DEF = 20;

    localparam logic [SUM_W-1:0] NO_PATH = '1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_MERGE,
        ST_RESULT
    } top_state_t;

    typedef enum logic [1:0] {
        M_IDLE,
        M_ISSUE,
        M_CMP
    } merge_state_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic found;
    } merge_stat_t;

endpackage

### hw/rtl/hlq_label_ram.sv
module hlq_label_ram #(
    parameter int DEPTH = hlq_pkg::MAX_LABELS_DEF,
    parameter int AW    = 10,
    parameter int DW    = 51
) (
    input  logic          clk,
    input  logic          wen,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          ren,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ren)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/hlq_merge.sv
module hlq_merge #(
    parameter int CW = 11,
    parameter int AW = 10,
    parameter int VW = 20
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [CW-1:0]              first_count,
    input  logic [CW-1:0]              second_count,
    input  logic [VW-1:0]              first_vtx,
    input  logic [hlq_pkg::HUB_DIST_W-1:0] first_dist,
    input  logic [VW-1:0]              second_vtx,
    input  logic [hlq_pkg::HUB_DIST_W-1:0] second_dist,
    output logic                       rd_en,
    output logic [AW-1:0]              first_addr,
    output logic [AW-1:0]              second_addr,
    output logic [hlq_pkg::SUM_W-1:0]  best,
    output hlq_pkg::merge_stat_t       stat
);

    hlq_pkg::merge_state_t state_reg, state_next;
    logic [CW-1:0]             i_reg, j_reg;
    logic [hlq_pkg::SUM_W-1:0] best_reg;
    logic                      found_reg;
    logic                      more;
    logic [hlq_pkg::SUM_W-1:0] sum;

    assign more = (i_reg < first_count) && (j_reg < second_count);
    assign sum  = {1'b0, first_dist} + {1'b0, second_dist};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hlq_pkg::M_IDLE:  if (start) state_next = hlq_pkg::M_ISSUE;
            hlq_pkg::M_ISSUE: state_next = more ? hlq_pkg::M_CMP : hlq_pkg::M_IDLE;
            hlq_pkg::M_CMP:   state_next = hlq_pkg::M_ISSUE;
            default:          state_next = hlq_pkg::M_IDLE;
        endcase
    end

    always_comb
    begin
        rd_en      = 1'b0;
        stat.busy  = 1'b0;
        stat.done  = 1'b0;
        stat.found = found_reg;
        case (state_reg)
            hlq_pkg::M_IDLE:
            begin
            end
            hlq_pkg::M_ISSUE:
            begin
                stat.busy = 1'b1;
                rd_en     = more;
                stat.done = !more;
            end
            hlq_pkg::M_CMP:   stat.busy = 1'b1;
            default:
            begin
            end
        endcase
    end

    assign best        = best_reg;
    assign first_addr  = i_reg[AW-1:0];
    assign second_addr = j_reg[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hlq_pkg::M_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == hlq_pkg::M_IDLE && start)
            begin
                i_reg     <= '0;
                j_reg     <= '0;
                found_reg <= 1'b0;
            end
            else if (state_reg == hlq_pkg::M_CMP)
            begin
                // read data for the pair (i, j) arrives in this cycle
                if (first_vtx == second_vtx)
                begin
                    i_reg     <= i_reg + 1'b1;
                    j_reg     <= j_reg + 1'b1;
                    found_reg <= 1'b1;
                end
                else if (first_vtx < second_vtx)
                begin
                    i_reg <= i_reg + 1'b1;
                end
                else
                begin
                    j_reg <= j_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == hlq_pkg::M_IDLE && start)
        begin
            best_reg <= hlq_pkg::NO_PATH;
        end
        else if (state_reg == hlq_pkg::M_CMP && first_vtx == second_vtx && sum < best_reg)
        begin
            best_reg <= sum;
        end
    end

endmodule

### hw/rtl/hub_label_distance_query.sv
// hub label distance query
// slave stream: one label entry per transfer. tdata carries hub_vertex and
// hub_distance, tuser carries list_select and entry_valid, tlast closes the
// list named by list_select. an entry with entry_valid low stores nothing.
// each list holds up to MAX_LABELS entries; extra entries are dropped and
// reported through list_overflow.
// master stream: one transfer per query, sent once both lists are closed:
// tdata = best_distance (all ones when no hub is shared), tuser holds
// found_common and list_overflow.
// label entries are accepted while loading. the transfer that closes the
// second list starts the merge: each merge step on the shared compare/add
// unit is one ram read, then one compare, at most first_count + second_count
// steps, then a last check ends it; tready stays low for that time.
// a finished result waits in the output register while a receiver stalls and
// entries of the next query keep loading; only the next merge result waits.
// reset empties both lists and drops a pending result. the label rams are
// not cleared: a query only reads entries written during that query.
module hub_label_distance_query #(
    parameter int MAX_LABELS  = hlq_pkg::MAX_LABELS_DEF,
    parameter int VERTEX_BITS = hlq_pkg::VERTEX_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hlq_pkg::S_TDATA_W-1:0] s_tdata,  // hub_vertex, hub_distance, zero pad
    input  logic [hlq_pkg::S_TUSER_W-1:0] s_tuser,  // list_select, entry_valid
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hlq_pkg::M_TDATA_W-1:0] m_tdata,  // best_distance
    output logic [hlq_pkg::M_TUSER_W-1:0] m_tuser   // found_common, list_overflow
);

    localparam int CW = $clog2(MAX_LABELS + 1);
    localparam int AW = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
    localparam int VW = (VERTEX_BITS < hlq_pkg::HUB_VERTEX_W) ? VERTEX_BITS
                                                               : hlq_pkg::HUB_VERTEX_W;
    localparam int DW = VW + hlq_pkg::HUB_DIST_W;

    hlq_pkg::top_state_t state_reg, state_next;
    logic [CW-1:0] first_count_reg, second_count_reg;
    logic          first_done_reg, second_done_reg, dropped_reg;
    logic          m_tvalid_reg;
    logic [hlq_pkg::SUM_W-1:0] m_best_reg;
    logic          m_found_reg, m_ovf_reg;

    logic sel, ev, accept, ignore, full, store, drop;
    logic first_done_next, second_done_next, both_done;
    logic merge_start, out_free, result_load;
    logic [VW-1:0]                   vtx;
    logic [hlq_pkg::HUB_DIST_W-1:0]  hub_dist;
    logic [DW-1:0]                   wdata, first_rdata, second_rdata;
    logic                            rd_en;
    logic [AW-1:0]                   first_raddr, second_raddr;
    logic [hlq_pkg::SUM_W-1:0]       best;
    hlq_pkg::merge_stat_t            stat;

    assign sel      = s_tuser[hlq_pkg::S_SEL_BIT];
    assign ev       = s_tuser[hlq_pkg::S_VALID_BIT];
    assign vtx      = s_tdata[hlq_pkg::S_VTX_LSB +: VW];
    assign hub_dist = s_tdata[hlq_pkg::S_DIST_LSB +: hlq_pkg::HUB_DIST_W];
    assign wdata    = {hub_dist, vtx};
    assign accept   = s_tvalid && s_tready;
    // entries for a list that is already closed are ignored
    assign ignore = sel ? second_done_reg : first_done_reg;
    assign full   = sel ? (second_count_reg >= CW'(MAX_LABELS))
                        : (first_count_reg >= CW'(MAX_LABELS));
    assign store  = accept && !ignore && ev && !full;
    assign drop   = accept && !ignore && ev && full;

    assign first_done_next  = first_done_reg || (accept && !sel && s_tlast);
    assign second_done_next = second_done_reg || (accept && sel && s_tlast);
    assign both_done        = first_done_next && second_done_next;
    assign out_free         = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hlq_pkg::ST_LOAD:   if (accept && both_done) state_next = hlq_pkg::ST_MERGE;
            hlq_pkg::ST_MERGE:  if (stat.done) state_next = hlq_pkg::ST_RESULT;
            hlq_pkg::ST_RESULT: if (out_free) state_next = hlq_pkg::ST_LOAD;
            default:            state_next = hlq_pkg::ST_LOAD;
        endcase
    end

    always_comb
    begin
        s_tready    = 1'b0;
        merge_start = 1'b0;
        result_load = 1'b0;
        case (state_reg)
            hlq_pkg::ST_LOAD:
            begin
                s_tready    = 1'b1;
                merge_start = accept && both_done;
            end
            hlq_pkg::ST_MERGE:
            begin
            end
            hlq_pkg::ST_RESULT: result_load = out_free;
            default:
            begin
            end
        endcase
    end

    hlq_label_ram #(
        .DEPTH (MAX_LABELS),
        .AW    (AW),
        .DW    (DW)
    ) u_first_ram (
        .clk   (clk),
        .wen   (store && !sel),
        .waddr (first_count_reg[AW-1:0]),
        .wdata (wdata),
        .ren   (rd_en),
        .raddr (first_raddr),
        .rdata (first_rdata)
    );

    hlq_label_ram #(
        .DEPTH (MAX_LABELS),
        .AW    (AW),
        .DW    (DW)
    ) u_second_ram (
        .clk   (clk),
        .wen   (store && sel),
        .waddr (second_count_reg[AW-1:0]),
        .wdata (wdata),
        .ren   (rd_en),
        .raddr (second_raddr),
        .rdata (second_rdata)
    );

    hlq_merge #(
        .CW (CW),
        .AW (AW),
        .VW (VW)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (merge_start),
        .first_count  (first_count_reg),
        .second_count (second_count_reg),
        .first_vtx    (first_rdata[VW-1:0]),
        .first_dist   (first_rdata[DW-1:VW]),
        .second_vtx   (second_rdata[VW-1:0]),
        .second_dist  (second_rdata[DW-1:VW]),
        .rd_en        (rd_en),
        .first_addr   (first_raddr),
        .second_addr  (second_raddr),
        .best         (best),
        .stat         (stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= hlq_pkg::ST_LOAD;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            first_done_reg   <= 1'b0;
            second_done_reg  <= 1'b0;
            dropped_reg      <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (result_load)
            begin
                first_count_reg  <= '0;
                second_count_reg <= '0;
                first_done_reg   <= 1'b0;
                second_done_reg  <= 1'b0;
                dropped_reg      <= 1'b0;
            end
            else
            begin
                if (store && !sel) first_count_reg <= first_count_reg + 1'b1;
                if (store && sel)  second_count_reg <= second_count_reg + 1'b1;
                if (drop)          dropped_reg <= 1'b1;
                first_done_reg  <= first_done_next;
                second_done_reg <= second_done_next;
            end
            if (result_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            m_best_reg  <= best;
            m_found_reg <= stat.found;
            m_ovf_reg   <= dropped_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_best_reg;
    assign m_tuser  = {m_ovf_reg, m_found_reg};

    // the merge unit only finishes while the top waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> state_reg == hlq_pkg::ST_MERGE)
        else $error("merge finished outside merge state");

    assert property (@(posedge clk) disable iff (!rst_n)
        first_count_reg <= CW'(MAX_LABELS) && second_count_reg <= CW'(MAX_LABELS))
        else $error("label count beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_load |=> first_count_reg == '0 && second_count_reg == '0
                        && !first_done_reg && !second_done_reg && !dropped_reg)
        else $error("query state not cleared after result");

    // a shared hub gives a sum below all ones
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> m_found_reg == (m_best_reg != hlq_pkg::NO_PATH))
        else $error("found flag disagrees with best distance");

    assert property (@(posedge clk) disable iff (!rst_n)
        stat.busy |-> !s_tready)
        else $error("entry accepted during merge");

endmodule

### tb/hub_label_distance_query_tb.sv
`timescale 1ns / 100ps

module hub_label_distance_query_tb;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 64;
    localparam int FOUND_BIT   = 0;
    localparam int OVF_BIT     = 1;
    localparam int RAND_ITEMS  = 1450;

    typedef logic [hlq_pkg::HUB_VERTEX_W-1:0] vtx_t;
    typedef logic [hlq_pkg::HUB_DIST_W-1:0]   dst_t;
    typedef logic [hlq_pkg::SUM_W-1:0]        sum_t;

    localparam vtx_t VTX_MAX  = '1;
    localparam dst_t DIST_MAX = '1;

    typedef struct {
        bit   sel;
        vtx_t vtx;
        dst_t dst;
        bit   valid;
        bit   last;
    } label_item_t;

    typedef struct {
        sum_t best_distance;
        bit   found_common;
        bit   list_overflow;
    } query_result_t;

    class query_scoreboard;
        vtx_t          first_vtx[$];
        vtx_t          second_vtx[$];
        dst_t          first_dst[$];
        dst_t          second_dst[$];
        bit            first_closed;
        bit            second_closed;
        bit            dropped;
        query_result_t answers[$];
        int            errors;
        int            labels_seen;
        int            results_seen;
        int            found_seen;
        int            overflow_seen;

        function int pending();
            return answers.size();
        endfunction

        task report(input string msg);
            if (errors < 30)
                $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        // merge walk over both lists, then start a fresh query
        function void join_lists();
            int            i;
            int            j;
            sum_t          sum;
            query_result_t r;
            i = 0;
            j = 0;
            r.best_distance = hlq_pkg::NO_PATH;
            r.found_common  = 1'b0;
            r.list_overflow = dropped;
            while (i < first_vtx.size() && j < second_vtx.size()) begin
                if (first_vtx[i] == second_vtx[j]) begin
                    sum = {1'b0, first_dst[i]} + {1'b0, second_dst[j]};
                    if (sum < r.best_distance)
                        r.best_distance = sum;
                    r.found_common = 1'b1;
                    i++;
                    j++;
                end
                else if (first_vtx[i] < second_vtx[j])
                    i++;
                else
                    j++;
            end
            answers = {answers, r};
            first_vtx.delete();
            first_dst.delete();
            second_vtx.delete();
            second_dst.delete();
            first_closed  = 1'b0;
            second_closed = 1'b0;
            dropped       = 1'b0;
        endfunction

        function void add_label(input label_item_t it);
            labels_seen++;
            if (it.sel == 1'b0) begin
                if (first_closed)
                    return;
                if (it.valid) begin
                    if (first_vtx.size() < hlq_pkg::MAX_LABELS_DEF) begin
                        first_vtx = {first_vtx, it.vtx};
                        first_dst = {first_dst, it.dst};
                    end
                    else
                        dropped = 1'b1;
                end
                if (it.last)
                    first_closed = 1'b1;
            end
            else begin
                if (second_closed)
                    return;
                if (it.valid) begin
                    if (second_vtx.size() < hlq_pkg::MAX_LABELS_DEF) begin
                        second_vtx = {second_vtx, it.vtx};
                        second_dst = {second_dst, it.dst};
                    end
                    else
                        dropped = 1'b1;
                end
                if (it.last)
                    second_closed = 1'b1;
            end
            if (first_closed && second_closed)
                join_lists();
        endfunction

        task check_answer(input sum_t best, input logic found, input logic ovf);
            query_result_t e;
            if (answers.size() == 0) begin
                report($sformatf("result %h/%b/%b with nothing expected", best, found, ovf));
                return;
            end
            e = answers.pop_front();
            results_seen++;
            if (e.found_common)
                found_seen++;
            if (e.list_overflow)
                overflow_seen++;
            if (best !== e.best_distance)
                report($sformatf("best_distance %h, expected %h", best, e.best_distance));
            if (found !== e.found_common)
                report($sformatf("found_common %b, expected %b", found, e.found_common));
            if (ovf !== e.list_overflow)
                report($sformatf("list_overflow %b, expected %b", ovf, e.list_overflow));
        endtask

        task check_drained();
            if (answers.size() != 0)
                report($sformatf("%0d results never arrived", answers.size()));
        endtask
    endclass

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [hlq_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [hlq_pkg::S_TUSER_W-1:0] s_tuser  = '0;
    logic                          s_tlast  = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [hlq_pkg::M_TDATA_W-1:0] m_tdata;
    logic [hlq_pkg::M_TUSER_W-1:0] m_tuser;

    query_scoreboard sb = new();
    int              cycles;
    int              items_sent;
    int              queries;
    bit              gaps_on;

    hub_label_distance_query dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("hub_label_distance_query verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        label_item_t it;
        if (rst_n && s_tvalid && s_tready === 1'b1) begin
            it.sel   = s_tuser[hlq_pkg::S_SEL_BIT];
            it.valid = s_tuser[hlq_pkg::S_VALID_BIT];
            it.vtx   = s_tdata[hlq_pkg::S_VTX_LSB +: hlq_pkg::HUB_VERTEX_W];
            it.dst   = s_tdata[hlq_pkg::S_DIST_LSB +: hlq_pkg::HUB_DIST_W];
            it.last  = s_tlast;
            sb.add_label(it);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready)
            sb.check_answer(m_tdata, m_tuser[FOUND_BIT], m_tuser[OVF_BIT]);
    end

    // receiver: ready bursts broken by stalls, now and then a long one
    initial
    begin
        int r;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            m_tready <= 1'b1;
            r = $urandom_range(0, 99);
            repeat ((r < 15) ? $urandom_range(100, 300) : $urandom_range(1, 40)) @(posedge clk);
            r = $urandom_range(0, 99);
            if (r >= 40) begin
                m_tready <= 1'b0;
                if (r < 75)
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                else if (r < 93)
                    repeat ($urandom_range(4, 15)) @(posedge clk);
                else
                    repeat ($urandom_range(30, 150)) @(posedge clk);
            end
        end
    end

    function automatic label_item_t mk(input bit sel, input vtx_t v, input dst_t d,
                                       input bit valid, input bit last);
        label_item_t it;
        it.sel   = sel;
        it.vtx   = v;
        it.dst   = d;
        it.valid = valid;
        it.last  = last;
        return it;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // called at a rising edge; returns at the edge of the transfer
    task automatic send_label(input label_item_t it);
        int gap;
        logic [hlq_pkg::S_TDATA_W-1:0] data;
        gap  = pick_gap();
        data = '0;
        data[hlq_pkg::S_VTX_LSB +: hlq_pkg::HUB_VERTEX_W] = it.vtx;
        data[hlq_pkg::S_DIST_LSB +: hlq_pkg::HUB_DIST_W]  = it.dst;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid                      <= 1'b1;
        s_tdata                       <= data;
        s_tuser[hlq_pkg::S_SEL_BIT]   <= it.sel;
        s_tuser[hlq_pkg::S_VALID_BIT] <= it.valid;
        s_tlast                       <= it.last;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic dst_t pick_dist(input int style);
        case (style)
            0:       return dst_t'($urandom_range(0, 1000));
            1:       return dst_t'($urandom());
            default: return DIST_MAX - dst_t'($urandom_range(0, 1000));
        endcase
    endfunction

    // one list: mostly sorted entries, with empty markers mixed in now and then
    task automatic build_list(input bit sel, input int unsigned base, input bit narrow,
                              input int dstyle, ref label_item_t q[$]);
        int unsigned vq[$];
        int          n;
        bit          marker_close;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 6);
        for (int k = 0; k < n; k++)
            vq = {vq, narrow ? ((base + $urandom_range(0, 15)) & VTX_MAX)
                             : ($urandom() & VTX_MAX)};
        if ($urandom_range(0, 9) != 0)
            vq.sort();
        marker_close = (n == 0) || ($urandom_range(0, 9) == 0);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0)
                q = {q, mk(sel, vtx_t'($urandom()), dst_t'($urandom()), 1'b0, 1'b0)};
            q = {q, mk(sel, vtx_t'(vq[k]), pick_dist(dstyle), 1'b1,
                       !marker_close && (k == n - 1))};
        end
        if (marker_close)
            q = {q, mk(sel, vtx_t'($urandom()), dst_t'($urandom()), 1'b0, 1'b1)};
    endtask

    task automatic random_query();
        label_item_t la[$];
        label_item_t lb[$];
        int          ia;
        int          ib;
        int unsigned base;
        bit          narrow;
        int          dstyle;
        bit          side;
        base   = $urandom() & VTX_MAX;
        narrow = $urandom_range(0, 4) != 0;
        dstyle = $urandom_range(0, 2);
        build_list(1'b0, base, narrow, dstyle, la);
        build_list(1'b1, base, narrow, dstyle, lb);
        ia = 0;
        ib = 0;
        while (ia < la.size() || ib < lb.size()) begin
            // traffic for a list that is already closed must be ignored
            if ((ia == la.size() || ib == lb.size()) && $urandom_range(0, 9) == 0)
                send_label(mk(ia == la.size() ? 1'b0 : 1'b1, vtx_t'($urandom()),
                              dst_t'($urandom()), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1))));
            if (ia == la.size())
                side = 1'b1;
            else if (ib == lb.size())
                side = 1'b0;
            else
                side = 1'($urandom_range(0, 1));
            if (side)
                send_label(lb[ib++]);
            else
                send_label(la[ia++]);
        end
        queries++;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        gaps_on = 1'b1;

        // extremes of vertex and distance
        send_label(mk(1'b0, '0, DIST_MAX, 1'b1, 1'b1));
        send_label(mk(1'b1, '0, DIST_MAX, 1'b1, 1'b1));
        send_label(mk(1'b1, VTX_MAX, '0, 1'b1, 1'b1));
        send_label(mk(1'b0, VTX_MAX, '0, 1'b1, 1'b1));
        // empty first list, no hub in common
        send_label(mk(1'b0, 20'h12345, 31'h1234, 1'b0, 1'b1));
        send_label(mk(1'b1, 20'h00007, 31'h0003, 1'b1, 1'b0));
        send_label(mk(1'b1, 20'h00009, 31'h0004, 1'b1, 1'b1));
        // closed list ignored, marker without last has no effect
        send_label(mk(1'b0, 20'd5, 31'd1, 1'b1, 1'b1));
        send_label(mk(1'b0, 20'd5, 31'd0, 1'b1, 1'b1));
        send_label(mk(1'b1, VTX_MAX, DIST_MAX, 1'b0, 1'b0));
        send_label(mk(1'b1, 20'd5, 31'd7, 1'b1, 1'b1));
        // both lists empty
        send_label(mk(1'b1, '0, '0, 1'b0, 1'b1));
        send_label(mk(1'b0, '0, '0, 1'b0, 1'b1));
        // unsorted lists: the walk finds one shared hub and skips the other
        send_label(mk(1'b0, 20'd10, 31'd2, 1'b1, 1'b0));
        send_label(mk(1'b1, 20'd3, 31'd1, 1'b1, 1'b0));
        send_label(mk(1'b0, 20'd3, 31'd1, 1'b1, 1'b1));
        send_label(mk(1'b1, 20'd10, 31'd5, 1'b1, 1'b1));
        // several shared hubs, the smallest sum wins
        send_label(mk(1'b0, 20'd1, 31'd9, 1'b1, 1'b0));
        send_label(mk(1'b1, 20'd2, 31'd8, 1'b1, 1'b0));
        send_label(mk(1'b0, 20'd2, 31'd4, 1'b1, 1'b0));
        send_label(mk(1'b0, 20'd3, 31'd1, 1'b1, 1'b1));
        send_label(mk(1'b1, 20'd3, 31'd2, 1'b1, 1'b1));
        queries = 7;
        wait_results();

        // first list overfills: entries past capacity dropped, the last still closes
        gaps_on = 1'b0;
        for (int k = 0; k <= hlq_pkg::MAX_LABELS_DEF + 1; k++) begin
            if (k == 10)
                send_label(mk(1'b1, 20'd100, 31'd5, 1'b1, 1'b0));
            if (k == 600)
                send_label(mk(1'b1, 20'(2 * (hlq_pkg::MAX_LABELS_DEF - 1)), 31'd7, 1'b1,
                              1'b0));
            send_label(mk(1'b0, 20'(2 * k), 31'(k), 1'b1, k == hlq_pkg::MAX_LABELS_DEF + 1));
        end
        send_label(mk(1'b1, 20'(2 * (hlq_pkg::MAX_LABELS_DEF + 1)), 31'd1, 1'b1, 1'b1));
        queries++;
        wait_results();

        while (items_sent < RAND_ITEMS) begin
            gaps_on = $urandom_range(0, 3) != 0;
            random_query();
            if ($urandom_range(0, 9) == 0)
                wait_results();
        end

        wait_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        sb.check_drained();
        $display("ran %0d queries over %0d label transfers, including overfilled and empty lists",
                 queries, sb.labels_seen);
        $display("checked %0d results: %0d with a shared hub, %0d with dropped entries",
                 sb.results_seen, sb.found_seen, sb.overflow_seen);
        if (sb.errors == 0)
            $display("hub_label_distance_query verification clean");
        else
            $display("hub_label_distance_query verification failed");
        $finish;
    end

endmodule

### files.f
hw/rtl/hlq_pkg.sv
hw/rtl/hlq_label_ram.sv
hw/rtl/hlq_merge.sv
hw/rtl/hub_label_distance_query.sv
tb/hub_label_distance_query_tb.sv
